/* design/assert_macros.svh */
// Shared assertion helpers, clocked on i_clk and quiet while i_rst_n is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`define WPHS_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) else $error(msg);

`define WPHS_NEVER(lbl, cond, msg) \
    `WPHS_ASSERT(lbl, !(cond), msg)

`endif

/* design/wphs_pkg.sv */
package wphs_pkg;

    localparam int POS_FRAC_BITS = 8;
    localparam int CORDIC_STEPS  = 16;

    localparam int POS_W   = 20;
    localparam int DIFF_W  = POS_W + 1;
    localparam int DIST_W  = 21;
    localparam int SQ_W    = 2 * DIST_W;
    localparam int REM_W   = DIST_W + 2;
    localparam int HEAD_W  = 16;
    localparam int SPD_W   = 16;
    localparam int THR_W   = 16;
    localparam int SCALE_W = 5;
    localparam int CW      = 24;
    localparam int ANG_W   = 32;
    localparam int ITER_W  = 5;

    localparam logic [ANG_W-1:0] QUARTER_TURN = 32'h4000_0000;
    localparam logic signed [22:0] PI_Q20 = 23'sd3294199;
    localparam int FAR_DIST = 1000 << POS_FRAC_BITS;

    typedef enum logic [0:0] {
        REG_THRESHOLD = 1'b0,
        REG_SCALE     = 1'b1
    } t_reg;

    typedef enum logic [0:0] {
        KIND_TARGET = 1'b0,
        KIND_POSE   = 1'b1
    } t_kind;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SQX,
        ST_SQY,
        ST_ROOT,
        ST_TGT,
        ST_PREP,
        ST_ROT,
        ST_ERR,
        ST_MUL1,
        ST_MUL2,
        ST_MUL3,
        ST_SPEED,
        ST_CMD,
        ST_STOP
    } t_state;

    typedef struct packed {
        logic [THR_W-1:0]   threshold;
        logic [SCALE_W-1:0] scale;
    } t_cfg;

    typedef struct packed {
        logic                     kind;
        logic signed [POS_W-1:0]  target_x;
        logic signed [POS_W-1:0]  target_y;
        logic signed [POS_W-1:0]  pose_x;
        logic signed [POS_W-1:0]  pose_y;
        logic signed [HEAD_W-1:0] heading;
    } t_item;

    function automatic logic [ANG_W-1:0] atan_entry(input logic [ITER_W-1:0] i);
        logic [ANG_W-1:0] v;
        case (i)
            5'd0:  v = 32'd536870912;
            5'd1:  v = 32'd316933406;
            5'd2:  v = 32'd167458907;
            5'd3:  v = 32'd85004756;
            5'd4:  v = 32'd42667331;
            5'd5:  v = 32'd21354465;
            5'd6:  v = 32'd10679838;
            5'd7:  v = 32'd5340245;
            5'd8:  v = 32'd2670163;
            5'd9:  v = 32'd1335087;
            5'd10: v = 32'd667544;
            5'd11: v = 32'd333772;
            5'd12: v = 32'd166886;
            5'd13: v = 32'd83443;
            5'd14: v = 32'd41722;
            5'd15: v = 32'd20861;
            5'd16: v = 32'd10430;
            5'd17: v = 32'd5215;
            5'd18: v = 32'd2608;
            5'd19: v = 32'd1304;
            5'd20: v = 32'd652;
            5'd21: v = 32'd326;
            5'd22: v = 32'd163;
            5'd23: v = 32'd81;
            default: v = '0;
        endcase
        return v;
    endfunction

    // divide by 2^42 truncating toward zero, then clamp to 16 bits
    function automatic logic [SPD_W-1:0] to_speed(input logic signed [63:0] v);
        logic signed [63:0] q;
        logic [SPD_W-1:0]   s;
        q = (v < 0) ? ((v + 64'sh3FF_FFFF_FFFF) >>> 42) : (v >>> 42);
        if (q > 64'sd32767) begin
            s = 16'h7FFF;
        end else if (q < -64'sd32768) begin
            s = 16'h8000;
        end else begin
            s = q[SPD_W-1:0];
        end
        return s;
    endfunction

endpackage

/* design/wphs_if.sv */
interface wphs_in_if;
    logic                                 valid;
    logic                                 ready;
    logic                                 kind;
    logic signed [wphs_pkg::POS_W-1:0]    target_x;
    logic signed [wphs_pkg::POS_W-1:0]    target_y;
    logic signed [wphs_pkg::POS_W-1:0]    pose_x;
    logic signed [wphs_pkg::POS_W-1:0]    pose_y;
    logic signed [wphs_pkg::HEAD_W-1:0]   heading;

    modport source(output valid, kind, target_x, target_y, pose_x, pose_y, heading,
                   input ready);
    modport sink(input valid, kind, target_x, target_y, pose_x, pose_y, heading,
                 output ready);
endinterface

interface wphs_out_if;
    logic                               valid;
    logic                               ready;
    logic signed [wphs_pkg::SPD_W-1:0]  left_speed;
    logic signed [wphs_pkg::SPD_W-1:0]  right_speed;
    logic                               last;

    modport source(output valid, left_speed, right_speed, last, input ready);
    modport sink(input valid, left_speed, right_speed, last, output ready);
endinterface

interface wphs_cfg_if;
    logic                               valid;
    logic                               ready;
    logic [0:0]                         index;
    logic [wphs_pkg::THR_W-1:0]         data;

    modport source(output valid, index, data, input ready);
    modport sink(input valid, index, data, output ready);
endinterface

/* design/wphs_front.sv */
module wphs_front (
    input  logic              i_clk,
    input  logic              i_rst_n,
    wphs_in_if.sink           i_in,
    output logic              o_q_valid,
    output wphs_pkg::t_item   o_q_item,
    input  logic              i_q_take
);
    wphs_pkg::t_item r_mem [2];
    logic            r_wr_ptr;
    logic            r_rd_ptr;
    logic [1:0]      r_count;
    logic            push;
    logic            pop;

    assign i_in.ready = (r_count != 2'd2);
    assign push       = i_in.valid && i_in.ready;
    assign pop        = i_q_take && o_q_valid;
    assign o_q_valid  = (r_count != 2'd0);
    assign o_q_item   = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wr_ptr] <= '{kind: i_in.kind, target_x: i_in.target_x,
                                 target_y: i_in.target_y, pose_x: i_in.pose_x,
                                 pose_y: i_in.pose_y, heading: i_in.heading};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            if (push) r_wr_ptr <= ~r_wr_ptr;
            if (pop)  r_rd_ptr <= ~r_rd_ptr;
            r_count <= r_count + 2'(push) - 2'(pop);
        end
    end
endmodule

/* design/wphs_back.sv */
`include "assert_macros.svh"

module wphs_back (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  wphs_pkg::t_cfg    i_cfg,
    input  logic              i_q_valid,
    input  wphs_pkg::t_item   i_q_item,
    output logic              o_q_take,
    wphs_out_if.source        o_out
);
    wphs_pkg::t_state r_state;
    wphs_pkg::t_state n_state;

    wphs_pkg::t_item                        r_item;
    logic signed [wphs_pkg::POS_W-1:0]      r_goal_x;
    logic signed [wphs_pkg::POS_W-1:0]      r_goal_y;
    logic [wphs_pkg::SPD_W-1:0]             r_base;
    logic [wphs_pkg::DIST_W-1:0]            r_prior;
    logic [wphs_pkg::DIST_W-1:0]            r_cur;
    logic                                   r_active;
    logic signed [wphs_pkg::DIFF_W-1:0]     r_dx;
    logic signed [wphs_pkg::DIFF_W-1:0]     r_dy;
    logic [wphs_pkg::SQ_W-1:0]              r_acc;
    logic [wphs_pkg::REM_W-1:0]             r_rem;
    logic [wphs_pkg::DIST_W-1:0]            r_root;
    logic [wphs_pkg::ITER_W-1:0]            r_iter;
    logic signed [wphs_pkg::CW-1:0]         r_cx;
    logic signed [wphs_pkg::CW-1:0]         r_cy;
    logic [wphs_pkg::ANG_W-1:0]             r_z;
    logic signed [23:0]                     r_e24;
    logic signed [40:0]                     r_p1;
    logic signed [43:0]                     r_ph;
    logic [41:0]                            r_pl;
    logic signed [63:0]                     r_term;
    logic [wphs_pkg::SPD_W-1:0]             r_left;
    logic [wphs_pkg::SPD_W-1:0]             r_right;
    logic                                   r_out_valid;
    logic [wphs_pkg::SPD_W-1:0]             r_out_left;
    logic [wphs_pkg::SPD_W-1:0]             r_out_right;
    logic                                   r_out_last;

    logic                                   out_free;
    logic                                   out_load;
    logic                                   take;
    logic signed [wphs_pkg::POS_W-1:0]      gx;
    logic signed [wphs_pkg::POS_W-1:0]      gy;
    logic [wphs_pkg::REM_W+1:0]             sh;
    logic [wphs_pkg::REM_W+1:0]             trial;
    logic                                   fits;
    logic [wphs_pkg::DIST_W-1:0]            root_nx;
    logic [25:0]                            base_prod;
    logic [17:0]                            base_full;
    logic                                   tgt_stop;
    logic                                   dist_stop;
    logic [wphs_pkg::ANG_W-1:0]             err_u;
    logic signed [wphs_pkg::ANG_W-1:0]      err_s;
    logic                                   err_big;
    logic                                   cy_pos;
    logic signed [wphs_pkg::CW-1:0]         sx;
    logic signed [wphs_pkg::CW-1:0]         sy;
    logic signed [63:0]                     whole;

    assign out_free = !r_out_valid || o_out.ready;
    assign out_load = ((r_state == wphs_pkg::ST_CMD) || (r_state == wphs_pkg::ST_STOP)) &&
                      out_free;
    assign take     = (r_state == wphs_pkg::ST_IDLE) && i_q_valid;
    assign o_q_take = take;

    assign o_out.valid       = r_out_valid;
    assign o_out.left_speed  = r_out_left;
    assign o_out.right_speed = r_out_right;
    assign o_out.last        = r_out_last;

    assign gx = (i_q_item.kind == wphs_pkg::KIND_TARGET) ? i_q_item.target_x : r_goal_x;
    assign gy = (i_q_item.kind == wphs_pkg::KIND_TARGET) ? i_q_item.target_y : r_goal_y;

    // one root bit per cycle
    assign sh      = {r_rem, r_acc[wphs_pkg::SQ_W-1 -: 2]};
    assign trial   = {2'b00, r_root, 2'b01};
    assign fits    = (sh >= trial);
    assign root_nx = {r_root[wphs_pkg::DIST_W-2:0], fits};

    assign base_prod = 26'(i_cfg.scale) * 26'(r_root);
    assign base_full = base_prod[25:wphs_pkg::POS_FRAC_BITS];
    assign tgt_stop  = (22'(r_root) <= 22'(i_cfg.threshold)) ||
                       (22'(r_root) > 22'(wphs_pkg::FAR_DIST) + 22'(i_cfg.threshold));
    assign dist_stop = (22'(r_cur) <= 22'(i_cfg.threshold)) ||
                       (22'(r_cur) > 22'(r_prior) + 22'(i_cfg.threshold));

    assign err_u   = r_z - {r_item.heading, 16'h0000};
    assign err_s   = $signed(err_u);
    assign err_big = (err_s > $signed(wphs_pkg::QUARTER_TURN)) ||
                     (err_s < -$signed(wphs_pkg::QUARTER_TURN));

    assign cy_pos = (r_cy > 0);
    assign sx     = r_cx >>> r_iter;
    assign sy     = r_cy >>> r_iter;
    assign whole  = $signed(64'(r_base) << 42);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= wphs_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            wphs_pkg::ST_IDLE: begin
                if (take) begin
                    if (i_q_item.kind == wphs_pkg::KIND_TARGET || r_active) begin
                        n_state = wphs_pkg::ST_SQX;
                    end
                end
            end
            wphs_pkg::ST_SQX: n_state = wphs_pkg::ST_SQY;
            wphs_pkg::ST_SQY: n_state = wphs_pkg::ST_ROOT;
            wphs_pkg::ST_ROOT: begin
                if (r_iter == '0) begin
                    n_state = (r_item.kind == wphs_pkg::KIND_TARGET) ?
                              wphs_pkg::ST_TGT : wphs_pkg::ST_PREP;
                end
            end
            wphs_pkg::ST_TGT:  n_state = tgt_stop ? wphs_pkg::ST_STOP : wphs_pkg::ST_IDLE;
            wphs_pkg::ST_PREP: begin
                n_state = (r_dx == '0 && r_dy == '0) ? wphs_pkg::ST_ERR : wphs_pkg::ST_ROT;
            end
            wphs_pkg::ST_ROT: begin
                if (r_iter == wphs_pkg::ITER_W'(wphs_pkg::CORDIC_STEPS - 1)) begin
                    n_state = wphs_pkg::ST_ERR;
                end
            end
            wphs_pkg::ST_ERR:   n_state = err_big ? wphs_pkg::ST_STOP : wphs_pkg::ST_MUL1;
            wphs_pkg::ST_MUL1:  n_state = wphs_pkg::ST_MUL2;
            wphs_pkg::ST_MUL2:  n_state = wphs_pkg::ST_MUL3;
            wphs_pkg::ST_MUL3:  n_state = wphs_pkg::ST_SPEED;
            wphs_pkg::ST_SPEED: n_state = wphs_pkg::ST_CMD;
            wphs_pkg::ST_CMD: begin
                if (out_free) begin
                    n_state = dist_stop ? wphs_pkg::ST_STOP : wphs_pkg::ST_IDLE;
                end
            end
            wphs_pkg::ST_STOP: begin
                if (out_free) n_state = wphs_pkg::ST_IDLE;
            end
            default: n_state = wphs_pkg::ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active    <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                wphs_pkg::ST_TGT:  r_active <= !tgt_stop;
                wphs_pkg::ST_ERR:  if (err_big) r_active <= 1'b0;
                wphs_pkg::ST_CMD:  if (out_free && dist_stop) r_active <= 1'b0;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        case (r_state)
            wphs_pkg::ST_IDLE: begin
                if (take) begin
                    r_item <= i_q_item;
                    r_dx   <= wphs_pkg::DIFF_W'(gx) - wphs_pkg::DIFF_W'(i_q_item.pose_x);
                    r_dy   <= wphs_pkg::DIFF_W'(gy) - wphs_pkg::DIFF_W'(i_q_item.pose_y);
                    if (i_q_item.kind == wphs_pkg::KIND_TARGET) begin
                        r_goal_x <= i_q_item.target_x;
                        r_goal_y <= i_q_item.target_y;
                    end
                end
            end
            wphs_pkg::ST_SQX: r_acc <= wphs_pkg::SQ_W'(r_dx * r_dx);
            wphs_pkg::ST_SQY: begin
                r_acc  <= r_acc + wphs_pkg::SQ_W'(r_dy * r_dy);
                r_rem  <= '0;
                r_root <= '0;
                r_iter <= wphs_pkg::ITER_W'(wphs_pkg::DIST_W - 1);
            end
            wphs_pkg::ST_ROOT: begin
                r_rem  <= fits ? wphs_pkg::REM_W'(sh - trial) : wphs_pkg::REM_W'(sh);
                r_root <= root_nx;
                r_acc  <= r_acc << 2;
                r_iter <= r_iter - 1'b1;
            end
            wphs_pkg::ST_TGT: begin
                r_cur   <= r_root;
                r_prior <= r_root;
                r_base  <= (base_full > 18'd65535) ? 16'hFFFF : base_full[15:0];
            end
            wphs_pkg::ST_PREP: begin
                r_prior <= r_cur;
                r_cur   <= r_root;
                r_iter  <= '0;
                r_z     <= '0;
                // angle measured from the dy axis; fold the left half plane first
                if (r_dy < 0) begin
                    if (r_dx >= 0) begin
                        r_cx <= wphs_pkg::CW'(r_dx);
                        r_cy <= -wphs_pkg::CW'(r_dy);
                        r_z  <= wphs_pkg::QUARTER_TURN;
                    end else begin
                        r_cx <= -wphs_pkg::CW'(r_dx);
                        r_cy <= wphs_pkg::CW'(r_dy);
                        r_z  <= 32'h0 - wphs_pkg::QUARTER_TURN;
                    end
                end else begin
                    r_cx <= wphs_pkg::CW'(r_dy);
                    r_cy <= wphs_pkg::CW'(r_dx);
                end
            end
            wphs_pkg::ST_ROT: begin
                if (cy_pos) begin
                    r_cx <= r_cx + sy;
                    r_cy <= r_cy - sx;
                    r_z  <= r_z + wphs_pkg::atan_entry(r_iter);
                end else begin
                    r_cx <= r_cx - sy;
                    r_cy <= r_cy + sx;
                    r_z  <= r_z - wphs_pkg::atan_entry(r_iter);
                end
                r_iter <= r_iter + 1'b1;
            end
            wphs_pkg::ST_ERR:  r_e24 <= err_s[31:8];
            wphs_pkg::ST_MUL1: r_p1 <= $signed({1'b0, r_base}) * r_e24;
            wphs_pkg::ST_MUL2: begin
                r_ph <= $signed(r_p1[40:20]) * wphs_pkg::PI_Q20;
                r_pl <= r_p1[19:0] * 22'(wphs_pkg::PI_Q20);
            end
            wphs_pkg::ST_MUL3: r_term <= (64'(r_ph) <<< 20) + $signed(64'(r_pl));
            wphs_pkg::ST_SPEED: begin
                r_left  <= wphs_pkg::to_speed(whole + r_term);
                r_right <= wphs_pkg::to_speed(whole - r_term);
            end
            wphs_pkg::ST_CMD: begin
                if (out_free) begin
                    r_out_left  <= r_left;
                    r_out_right <= r_right;
                    r_out_last  <= 1'b0;
                end
            end
            wphs_pkg::ST_STOP: begin
                if (out_free) begin
                    r_out_left  <= '0;
                    r_out_right <= '0;
                    r_out_last  <= 1'b1;
                end
            end
            default: ;
        endcase
    end

    `WPHS_ASSERT(a_stop_zero,
        r_out_valid && r_out_last |-> r_out_left == '0 && r_out_right == '0,
        "stop beat carries nonzero speed")
    `WPHS_ASSERT(a_rot_active,
        r_state == wphs_pkg::ST_ROT |-> r_active && r_item.kind == wphs_pkg::KIND_POSE,
        "cordic running while idle")
    `WPHS_NEVER(a_root_iter,
        r_state == wphs_pkg::ST_ROOT && r_iter > wphs_pkg::ITER_W'(wphs_pkg::DIST_W - 1),
        "root counter out of range")
endmodule

/* design/waypoint_heading_steering.sv */
// Differential-drive waypoint steering. A target beat (kind 0) loads the waypoint, measures the
// distance and either arms steering silently or returns one stop beat; a pose beat (kind 1)
// while armed returns a motor beat, followed by a stop beat on arrival or divergence, or a
// lone stop beat when the heading error is beyond a quarter turn. A target beat and an armed
// pose beat run the one-bit-per-cycle square root, and a pose beat then the 16-step CORDIC,
// both run by one sequencer; a pose beat while idle is taken and dropped. Output stalls hold
// the sequencer in its command or stop state. Up to two input beats queue ahead of it and a
// finished beat waits in the output register. Config writes are accepted every cycle.
module waypoint_heading_steering (
    input  logic        i_clk,
    input  logic        i_rst_n,
    wphs_in_if.sink     i_in,
    wphs_out_if.source  o_out,
    wphs_cfg_if.sink    i_cfg
);
    wphs_pkg::t_cfg  r_cfg;
    logic            q_valid;
    wphs_pkg::t_item q_item;
    logic            q_take;

    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.threshold <= 16'd1024;
            r_cfg.scale     <= 5'd5;
        end else if (i_cfg.valid) begin
            case (i_cfg.index)
                wphs_pkg::REG_THRESHOLD: r_cfg.threshold <= i_cfg.data;
                wphs_pkg::REG_SCALE:     r_cfg.scale <= i_cfg.data[wphs_pkg::SCALE_W-1:0];
                default: ;
            endcase
        end
    end

    wphs_front u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_in      (i_in),
        .o_q_valid (q_valid),
        .o_q_item  (q_item),
        .i_q_take  (q_take)
    );

    wphs_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cfg     (r_cfg),
        .i_q_valid (q_valid),
        .i_q_item  (q_item),
        .o_q_take  (q_take),
        .o_out     (o_out)
    );
endmodule

/* verif/waypoint_heading_steering_tb.sv */
`timescale 1ns / 1ps

module waypoint_heading_steering_tb;
    import wphs_pkg::*;

    localparam int STALL_LIMIT = 5000;
    localparam int SETTLE_CYCLES = 200;
    localparam int N_ITEMS = 550;
    localparam int RX_HOLD = 600;

    typedef struct {
        logic signed [SPD_W-1:0] left_speed;
        logic signed [SPD_W-1:0] right_speed;
        logic                    last;
    } t_cmd;

    // how a directed row is checked: by the steering model, no beat, or one stop beat
    typedef enum int {CHK_MODEL, CHK_NONE, CHK_STOP} t_chk;

    typedef struct {
        t_item it;
        t_chk  chk;
    } t_row;

    localparam logic [31:0] ATAN_Q32 [24] = '{
        32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756, 32'd42667331,
        32'd21354465, 32'd10679838, 32'd5340245, 32'd2670163, 32'd1335087, 32'd667544,
        32'd333772, 32'd166886, 32'd83443, 32'd41722, 32'd20861, 32'd10430, 32'd5215,
        32'd2608, 32'd1304, 32'd652, 32'd326, 32'd163, 32'd81
    };

    logic i_clk;
    logic i_rst_n;

    wphs_in_if  in_if();
    wphs_out_if out_if();
    wphs_cfg_if cfg_if();

    waypoint_heading_steering dut (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_in   (in_if),
        .o_out  (out_if),
        .i_cfg  (cfg_if)
    );

    // steering model state
    logic [THR_W-1:0]   m_thr;
    logic [SCALE_W-1:0] m_scale;
    longint             m_goal_x, m_goal_y;
    longint unsigned    m_base, m_prior, m_dist;
    bit                 m_active;

    t_cmd cmd_q[$];
    int   errors;
    int   results_seen;
    int   quiet_cycles;
    int   hold_left;
    bit   held;
    bit   tx_calm;

    always begin
        i_clk = 1'b0;
        #10;
        i_clk = 1'b1;
        #10;
    end

    function automatic longint unsigned isqrt(longint unsigned n);
        longint unsigned r, b;
        r = 0;
        b = 64'd1 << 62;
        while (b > n) b >>= 2;
        while (b != 0) begin
            if (n >= r + b) begin
                n -= r + b;
                r = (r >> 1) + b;
            end else begin
                r >>= 1;
            end
            b >>= 2;
        end
        return r;
    endfunction

    function automatic longint unsigned range_to(longint px, longint py);
        longint dx, dy;
        dx = m_goal_x - px;
        dy = m_goal_y - py;
        return isqrt(dx * dx + dy * dy);
    endfunction

    // vectoring CORDIC, angle from the x axis toward y, 2^32 per turn
    function automatic logic [31:0] bearing_of(longint y, longint x);
        logic [31:0] z;
        longint nx, ny, t;
        z = '0;
        if (x == 0 && y == 0) return '0;
        if (x < 0) begin
            t = x;
            if (y >= 0) begin
                x = y; y = -t; z = QUARTER_TURN;
            end else begin
                x = -y; y = t; z = -QUARTER_TURN;
            end
        end
        for (int i = 0; i < CORDIC_STEPS && i < 24; i++) begin
            if (y > 0) begin
                nx = x + (y >>> i); ny = y - (x >>> i); z += ATAN_Q32[i];
            end else begin
                nx = x - (y >>> i); ny = y + (x >>> i); z -= ATAN_Q32[i];
            end
            x = nx;
            y = ny;
        end
        return z;
    endfunction

    function automatic logic signed [SPD_W-1:0] clamp16(longint v);
        if (v > 32767) return 16'sh7FFF;
        if (v < -32768) return 16'sh8000;
        return v[SPD_W-1:0];
    endfunction

    function automatic int steer_predict(input t_item it, output t_cmd r [2]);
        longint px, py, e, e24, term, whole;
        longint unsigned b;
        logic [31:0] z, u;
        int n;
        t_cmd stop;
        n = 0;
        stop = '{0, 0, 1'b1};
        r[0] = stop;
        r[1] = stop;
        px = it.pose_x;
        py = it.pose_y;
        if (it.kind == KIND_TARGET) begin
            m_goal_x = it.target_x;
            m_goal_y = it.target_y;
            m_dist = range_to(px, py);
            m_prior = m_dist;
            b = (longint'(m_scale) * m_dist) >> POS_FRAC_BITS;
            m_base = (b > 65535) ? 65535 : b;
            if (m_dist <= m_thr || m_dist > longint'(FAR_DIST) + m_thr) begin
                m_active = 0;
                return 1;
            end
            m_active = 1;
            return 0;
        end
        if (!m_active) return 0;
        m_prior = m_dist;
        m_dist = range_to(px, py);
        z = bearing_of(m_goal_x - px, m_goal_y - py);
        u = z - {it.heading, 16'h0000};
        e = longint'($signed(u));
        if (e > longint'(QUARTER_TURN) || e < -longint'(QUARTER_TURN)) begin
            m_active = 0;
            return 1;
        end
        e24 = e >>> 8;
        term = longint'(m_base) * e24 * longint'(PI_Q20);
        whole = longint'(m_base) << 42;
        r[0] = '{clamp16((whole + term) / (64'sd1 <<< 42)),
                 clamp16((whole - term) / (64'sd1 <<< 42)), 1'b0};
        n = 1;
        if (m_dist <= m_thr || m_dist > m_prior + m_thr) begin
            m_active = 0;
            n = 2;
        end
        return n;
    endfunction

    task automatic idle_cycles(int n);
        in_if.valid <= 1'b0;
        repeat (n) @(posedge i_clk);
    endtask

    // drive one beat, return after it is taken; valid stays high for the caller
    task automatic send_beat(input t_item it, input t_chk chk);
        t_cmd r [2];
        int n;
        if (!tx_calm && $urandom_range(99) < 15) idle_cycles($urandom_range(1, 4));
        in_if.valid    <= 1'b1;
        in_if.kind     <= it.kind;
        in_if.target_x <= it.target_x;
        in_if.target_y <= it.target_y;
        in_if.pose_x   <= it.pose_x;
        in_if.pose_y   <= it.pose_y;
        in_if.heading  <= it.heading;
        do @(posedge i_clk); while (!in_if.ready);
        n = steer_predict(it, r);
        case (chk)
            CHK_NONE: n = 0;
            CHK_STOP: begin
                n = 1;
                r[0] = '{0, 0, 1'b1};
            end
            default: ;
        endcase
        for (int k = 0; k < n; k++) cmd_q.push_back(r[k]);
    endtask

    // valid stays high for the caller, who drops it after the last write
    task automatic write_reg(t_reg idx, logic [THR_W-1:0] val);
        cfg_if.valid <= 1'b1;
        cfg_if.index <= idx;
        cfg_if.data  <= val;
        do @(posedge i_clk); while (!cfg_if.ready);
        if (idx == REG_THRESHOLD) m_thr = val;
        else m_scale = val[SCALE_W-1:0];
    endtask

    task automatic drain();
        in_if.valid <= 1'b0;
        while (cmd_q.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    function automatic t_item mk(t_kind k, int tx, int ty, int px, int py, int hd);
        t_item it;
        it.kind = k;
        it.target_x = POS_W'(tx);
        it.target_y = POS_W'(ty);
        it.pose_x = POS_W'(px);
        it.pose_y = POS_W'(py);
        it.heading = HEAD_W'(hd);
        return it;
    endfunction

    function automatic t_item noise_item();
        t_item it;
        it.kind = 1'($urandom_range(1));
        it.target_x = POS_W'($urandom);
        it.target_y = POS_W'($urandom);
        it.pose_x = POS_W'($urandom);
        it.pose_y = POS_W'($urandom);
        it.heading = HEAD_W'($urandom);
        return it;
    endfunction

    // a target followed by poses closing in on it, heading roughly on course
    task automatic run_segment(ref int sent);
        longint gx, gy, sx, sy, px, py, span;
        int steps, jit;
        t_item it;
        logic [31:0] z;
        span = ($urandom_range(3) == 0) ? 150000 : 8000;
        gx = $signed($urandom_range(600000)) - 300000;
        gy = $signed($urandom_range(600000)) - 300000;
        sx = gx - ($signed($urandom_range(2 * span)) - span);
        sy = gy - ($signed($urandom_range(2 * span)) - span);
        send_beat(mk(KIND_TARGET, int'(gx), int'(gy), int'(sx), int'(sy), int'($urandom)),
                  CHK_MODEL);
        sent++;
        steps = $urandom_range(2, 10);
        for (int k = 1; k <= steps; k++) begin
            px = sx + (gx - sx) * k / (steps + 1) + $signed($urandom_range(400)) - 200;
            py = sy + (gy - sy) * k / (steps + 1) + $signed($urandom_range(400)) - 200;
            if (k == steps && $urandom_range(1)) begin
                px = gx + $signed($urandom_range(200)) - 100;
                py = gy;
            end
            z = bearing_of(gx - px, gy - py);
            jit = ($urandom_range(9) == 0) ? $urandom_range(40000) : $urandom_range(6000);
            it = mk(KIND_POSE, int'($urandom), int'($urandom), int'(px), int'(py),
                    $signed(z[31:16]) + jit - 3000);
            send_beat(it, CHK_MODEL);
            sent++;
        end
    endtask

    always @(posedge i_clk) begin
        if (out_if.valid && out_if.ready) begin
            results_seen <= results_seen + 1;
            if (cmd_q.size() == 0) begin
                $error("unexpected result beat: left %0d right %0d last %0d",
                       out_if.left_speed, out_if.right_speed, out_if.last);
                errors++;
            end else begin
                t_cmd x;
                x = cmd_q.pop_front();
                if (out_if.left_speed !== x.left_speed) begin
                    $error("left_speed expected %0d actual %0d", x.left_speed,
                           out_if.left_speed);
                    errors++;
                end
                if (out_if.right_speed !== x.right_speed) begin
                    $error("right_speed expected %0d actual %0d", x.right_speed,
                           out_if.right_speed);
                    errors++;
                end
                if (out_if.last !== x.last) begin
                    $error("last expected %0d actual %0d", x.last, out_if.last);
                    errors++;
                end
            end
        end
    end

    // receiver: random backpressure, one long hold, one calm stretch
    always @(posedge i_clk) begin
        if (hold_left > 0) begin
            out_if.ready <= 1'b0;
            hold_left <= hold_left - 1;
        end else if (!held && results_seen >= 120) begin
            held <= 1'b1;
            hold_left <= RX_HOLD;
            out_if.ready <= 1'b0;
        end else if (results_seen >= 300 && results_seen < 420) begin
            out_if.ready <= 1'b1;
        end else begin
            out_if.ready <= ($urandom_range(99) >= 15);
        end
    end

    always @(posedge i_clk) begin
        if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready) ||
            (cfg_if.valid && cfg_if.ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= STALL_LIMIT) begin
            $display("*** FAILED ***");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin
        t_row rows [$];
        int sent;
        int phase;
        logic [THR_W-1:0] thr_set [6] = '{16'd1024, 16'd0, 16'd65535, 16'd200, 16'd4000,
                                          16'd1024};
        logic [THR_W-1:0] scale_set [6] = '{16'd5, 16'd31, 16'd0, 16'd17, 16'd31, 16'd5};

        errors = 0;
        results_seen = 0;
        quiet_cycles = 0;
        hold_left = 0;
        held = 0;
        tx_calm = 0;
        m_thr = 16'd1024;
        m_scale = 5'd5;
        m_goal_x = 0;
        m_goal_y = 0;
        m_base = 0;
        m_prior = 0;
        m_dist = 0;
        m_active = 0;
        i_rst_n = 1'b0;
        in_if.valid = 1'b0;
        in_if.kind = KIND_TARGET;
        in_if.target_x = '0;
        in_if.target_y = '0;
        in_if.pose_x = '0;
        in_if.pose_y = '0;
        in_if.heading = '0;
        out_if.ready = 1'b0;
        cfg_if.valid = 1'b0;
        cfg_if.index = REG_THRESHOLD;
        cfg_if.data = '0;

        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        rows = '{
            '{mk(KIND_POSE, 0, 0, 5000, 5000, 0), CHK_NONE},
            '{mk(KIND_TARGET, 0, 0, 0, 0, 0), CHK_STOP},
            '{mk(KIND_TARGET, 524287, 524287, -524288, -524288, 32767), CHK_STOP},
            '{mk(KIND_TARGET, 100000, 0, 0, 0, 16384), CHK_NONE},
            '{mk(KIND_POSE, 0, 0, 10000, 0, 16384), CHK_MODEL},
            '{mk(KIND_POSE, 0, 0, 10000, 0, -16384), CHK_STOP},
            '{mk(KIND_TARGET, 0, 50000, 0, 0, 0), CHK_NONE},
            '{mk(KIND_POSE, 0, 0, 0, 50000, -32768), CHK_STOP},
            '{mk(KIND_TARGET, 0, 50000, 0, 0, 0), CHK_NONE},
            '{mk(KIND_POSE, 0, 0, 0, 50000, 0), CHK_MODEL},
            '{mk(KIND_TARGET, 0, 50000, 0, 0, 0), CHK_NONE},
            '{mk(KIND_POSE, 0, 0, 0, -5000, 1200), CHK_MODEL},
            '{mk(KIND_TARGET, -524288, -524288, -524288, -500000, 0), CHK_NONE},
            '{mk(KIND_POSE, 0, 0, -524288, -520000, 32767), CHK_MODEL},
            '{mk(KIND_TARGET, 200000, 0, 0, 0, 0), CHK_NONE},
            '{mk(KIND_POSE, 0, 0, 0, 0, 1), CHK_MODEL},
            '{mk(KIND_POSE, 0, 0, 0, 0, 9000), CHK_MODEL},
            '{mk(KIND_POSE, 0, 0, 199000, 0, 16384), CHK_MODEL},
            '{mk(KIND_POSE, 0, 0, 199000, 0, 16384), CHK_NONE}
        };
        foreach (rows[i]) send_beat(rows[i].it, rows[i].chk);
        drain();

        sent = 0;
        for (phase = 0; phase < 6; phase++) begin
            write_reg(REG_THRESHOLD, thr_set[phase]);
            write_reg(REG_SCALE, scale_set[phase]);
            cfg_if.valid <= 1'b0;
            while (sent < (phase + 1) * N_ITEMS / 6) begin
                tx_calm = (sent >= 250 && sent < 330);
                if ($urandom_range(9) < 8) run_segment(sent);
                else begin
                    send_beat(noise_item(), CHK_MODEL);
                    sent++;
                end
            end
            // sender waits out every pending result before the next settings
            drain();
        end

        if (errors == 0 && cmd_q.size() == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule

/* filelist.f */
+incdir+design
design/wphs_pkg.sv
design/wphs_if.sv
design/wphs_front.sv
design/wphs_back.sv
design/waypoint_heading_steering.sv
verif/waypoint_heading_steering_tb.sv
